@@ hw/rtl/adaptive_client_throttle_unit_macros.svh @@
// Assertion helpers for the throttle unit
`ifndef ADAPTIVE_CLIENT_THROTTLE_UNIT_MACROS_SVH
`define ADAPTIVE_CLIENT_THROTTLE_UNIT_MACROS_SVH
// implication, checked every edge outside reset
`define ACT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ACT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/act_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_pkg
// Shared constants of the adaptive client throttle.
// ----------------------------------------------------------------------------
package act_pkg;
  localparam int WINDOW_SECONDS_DEF = 8;
  localparam int ENDPOINTS_DEF      = 16;
  localparam int BUCKET_W           = 16;
  localparam int TOTAL_W            = 19;
  localparam int KMUL_W             = 4;
  localparam logic [KMUL_W-1:0] KMUL_RESET = 4'd2;
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
endpackage

@@ hw/rtl/act_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface act_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] ip_address;
  logic [15:0] port_number;
  logic [31:0] current_second;
  logic        call_failed;
  logic [15:0] random_fraction;
  modport source (output valid, op, ip_address, port_number, current_second,
                  call_failed, random_fraction, input ready);
  modport sink (input valid, op, ip_address, port_number, current_second,
                call_failed, random_fraction, output ready);
endinterface

@@ hw/rtl/act_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_rsp_if
// Result channel: valid/ready handshake with the decision flags.
// ----------------------------------------------------------------------------
interface act_rsp_if;
  logic valid;
  logic ready;
  logic reject;
  logic entry_found;
  logic table_full;
  modport source (output valid, reject, entry_found, table_full, input ready);
  modport sink (input valid, reject, entry_found, table_full, output ready);
endinterface

@@ hw/rtl/act_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module act_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read; a write cycle reads back the old word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/adaptive_client_throttle_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_client_throttle_unit
// Per-endpoint adaptive throttle over a window of one-second buckets.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (op 0 reports a finished call, op 1 asks
// whether to reject). Each request yields one result on out_ch with reject,
// entry_found and table_full. The user must write accept_multiplier through
// cfg_we/cfg_wdata only while the unit is idle; the unit leaves this to the user.
// One request at a time: in_ch.ready is high only in the idle state. A
// sequencer scans the endpoint table one entry per cycle. A report then
// reduces the current and last second modulo WINDOW_SECONDS with one shared
// reciprocal multiplier and ages the bucket RAM: a stale window is wiped one
// bucket per cycle, otherwise each elapsed second is a read, a wait and a
// subtract that also zeroes the bucket, up to WINDOW_SECONDS-1 seconds.
// The next request can be taken in the cycle after the result is loaded.
// Reset: a clearing pass zeroes all ENDPOINTS*WINDOW_SECONDS buckets of the
// bucket RAM before the first request is taken; config writes are taken.
// The result sits in an output register until out_ch.ready; the next request
// is processed meanwhile and holds its own result until the register frees.
// ----------------------------------------------------------------------------
`include "adaptive_client_throttle_unit_macros.svh"
module adaptive_client_throttle_unit #(
  parameter int WINDOW_SECONDS = act_pkg::WINDOW_SECONDS_DEF,
  parameter int ENDPOINTS      = act_pkg::ENDPOINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  act_req_if.sink                     in_ch,
  act_rsp_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [act_pkg::KMUL_W-1:0]  cfg_wdata
);
  localparam int EW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam int SW = $clog2(WINDOW_SECONDS);
  localparam int NB = ENDPOINTS * WINDOW_SECONDS;
  localparam int BW = $clog2(NB);
  localparam int TW = act_pkg::TOTAL_W;
  localparam int KW = act_pkg::KMUL_W;
  localparam int BKW = act_pkg::BUCKET_W;
  localparam logic [TW-1:0]  TOT_MAX = {TW{1'b1}};
  localparam logic [BKW-1:0] BK_MAX  = {BKW{1'b1}};
  // reciprocal of the window length, exact quotient for any 32-bit second
  localparam logic [32:0] MOD_RECIP =
    33'(((64'd1 << (32 + SW)) / 64'(WINDOW_SECONDS)) + 64'd1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_MODA, S_MODB, S_ARD, S_AWAIT, S_ASUB,
    S_UPRD, S_UPWAIT, S_UPWR, S_QMUL, S_QCMP, S_OUT
  } state_t;

  state_t state_r;
  logic [KW-1:0] kmul_r;

  // endpoint table in flops (small, scanned one entry per cycle)
  logic [ENDPOINTS-1:0] valid_r;
  logic [31:0] addr_r [ENDPOINTS];
  logic [15:0] port_r [ENDPOINTS];
  logic [31:0] last_r [ENDPOINTS];
  logic [TW-1:0] treq_r [ENDPOINTS];
  logic [TW-1:0] tacc_r [ENDPOINTS];

  // latched request
  logic        op_r, failed_r;
  logic [31:0] ip_r, now_r;
  logic [15:0] pn_r, rnd_r;

  logic [EW:0]   scan_r;
  logic          hit_r, free_ok_r;
  logic [EW-1:0] hit_idx_r, free_idx_r, ent_r;
  logic [SW:0]   age_cnt_r;
  logic [SW-1:0] age_slot_r;
  logic [31:0]   elapsed_r;
  logic [SW-1:0] slot_r;
  logic          clr_all_r;
  logic [BW:0]   clr_r;
  logic [TW+KW-1:0] limit_r;
  logic [TW+16:0] lhs_r;

  // shared modulo unit
  logic          mod_sel_r;
  logic [64:0]   mod_prod_r;
  logic [31:0]   mod_x, mod_q, mod_qw;
  logic [SW-1:0] mod_res;

  logic          res_rej_r, res_found_r, res_full_r;
  logic          rsp_valid_r, rsp_rej_r, rsp_found_r, rsp_full_r;

  // bucket RAMs
  logic          ram_we;
  logic [BW-1:0] ram_addr;
  logic [BKW-1:0] req_wd, acc_wd, req_rd, acc_rd;

  act_ram #(.WIDTH(BKW), .DEPTH(NB)) u_req_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req_wd), .rdata(req_rd));
  act_ram #(.WIDTH(BKW), .DEPTH(NB)) u_acc_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(acc_wd), .rdata(acc_rd));

  logic [EW-1:0] scan_idx;
  assign scan_idx = scan_r[EW-1:0];

  logic [BW-1:0] ent_base;
  assign ent_base = BW'(ent_r) * BW'(WINDOW_SECONDS);

  // second modulo window: quotient by reciprocal, remainder in low bits
  assign mod_x   = mod_sel_r ? last_r[ent_r] : now_r;
  assign mod_q   = 32'(mod_prod_r >> (32 + SW));
  assign mod_qw  = mod_q * 32'(WINDOW_SECONDS);
  assign mod_res = mod_x[SW-1:0] - mod_qw[SW-1:0];

  // next ageing slot; a wrap of the second counter restarts at slot 0
  logic [31:0]   age_sec_nxt;
  logic [SW-1:0] age_slot_nxt;
  assign age_sec_nxt  = last_r[ent_r] + 32'(age_cnt_r) + 32'd1;
  assign age_slot_nxt = (age_sec_nxt == '0 || age_slot_r == SW'(WINDOW_SECONDS - 1)) ?
                        '0 : age_slot_r + 1'b1;

  // bucket RAM port control
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = ent_base + BW'(age_slot_r);
    req_wd   = '0;
    acc_wd   = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r[BW-1:0];
      end
      S_ASUB: begin
        ram_we   = 1'b1;
        ram_addr = clr_all_r ? ent_base + BW'(age_cnt_r[SW-1:0]) : ent_base + BW'(age_slot_r);
      end
      S_UPRD, S_UPWAIT: ram_addr = ent_base + BW'(slot_r);
      S_UPWR: begin
        ram_we   = 1'b1;
        ram_addr = ent_base + BW'(slot_r);
        req_wd   = (req_rd == BK_MAX) ? req_rd : req_rd + 1'b1;
        acc_wd   = (failed_r || acc_rd == BK_MAX) ? acc_rd : acc_rd + 1'b1;
      end
      default: ;
    endcase
  end

  logic entry_match;
  assign entry_match = valid_r[scan_idx] && addr_r[scan_idx] == ip_r &&
                       port_r[scan_idx] == pn_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      kmul_r      <= act_pkg::KMUL_RESET;
      valid_r     <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (cfg_we) kmul_r <= cfg_wdata;
      case (state_r)
        // zero the bucket RAM
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (BW+1)'(NB - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          op_r <= in_ch.op; ip_r <= in_ch.ip_address; pn_r <= in_ch.port_number;
          now_r <= in_ch.current_second; failed_r <= in_ch.call_failed;
          rnd_r <= in_ch.random_fraction;
          scan_r <= '0; hit_r <= 1'b0; free_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        // lowest matching entry and lowest free slot
        S_SCAN: begin
          if (!hit_r && entry_match) begin hit_r <= 1'b1; hit_idx_r <= scan_idx; end
          if (!free_ok_r && !valid_r[scan_idx]) begin
            free_ok_r <= 1'b1; free_idx_r <= scan_idx;
          end
          scan_r <= scan_r + 1'b1;
          if (scan_r == (EW+1)'(ENDPOINTS - 1)) state_r <= S_PICK;
        end
        S_PICK: begin
          res_found_r <= hit_r;
          res_full_r  <= 1'b0;
          res_rej_r   <= 1'b0;
          age_cnt_r   <= '0;
          mod_sel_r   <= 1'b0;
          if (hit_r) begin
            ent_r     <= hit_idx_r;
            elapsed_r <= now_r - last_r[hit_idx_r];
            clr_all_r <= (now_r - last_r[hit_idx_r]) >= 32'(WINDOW_SECONDS);
            state_r   <= (op_r == act_pkg::OP_QUERY) ? S_ARD : S_MODA;
          end else if (op_r == act_pkg::OP_REPORT && free_ok_r) begin
            // new entry: fresh totals, last second 0; clear all buckets
            ent_r <= free_idx_r;
            valid_r[free_idx_r] <= 1'b1;
            addr_r[free_idx_r]  <= ip_r;
            port_r[free_idx_r]  <= pn_r;
            last_r[free_idx_r]  <= '0;
            treq_r[free_idx_r]  <= '0;
            tacc_r[free_idx_r]  <= '0;
            elapsed_r <= now_r;
            clr_all_r <= 1'b1;
            state_r   <= S_MODA;
          end else begin
            res_full_r <= (op_r == act_pkg::OP_REPORT);
            state_r    <= S_OUT;
          end
        end
        // slot of the current second, then of the last second
        S_MODA: begin
          mod_prod_r <= 65'(mod_x) * 65'(MOD_RECIP);
          state_r    <= S_MODB;
        end
        S_MODB: begin
          if (!mod_sel_r) begin
            slot_r    <= mod_res;
            mod_sel_r <= 1'b1;
            state_r   <= S_MODA;
          end else begin
            age_slot_r <= mod_res;
            state_r    <= S_ARD;
          end
        end
        // ageing: full clear or per-second drops; a query skips the drops
        S_ARD: begin
          if (clr_all_r) begin
            treq_r[ent_r] <= '0; tacc_r[ent_r] <= '0;
            state_r <= S_ASUB;
          end else if (op_r == act_pkg::OP_QUERY) begin
            state_r <= S_QMUL;
          end else if (32'(age_cnt_r) == elapsed_r) begin
            state_r <= S_UPRD;
          end else begin
            age_cnt_r  <= age_cnt_r + 1'b1;
            age_slot_r <= age_slot_nxt;
            state_r    <= S_AWAIT;
          end
        end
        S_AWAIT: state_r <= S_ASUB;
        S_ASUB: begin
          if (clr_all_r) begin
            age_cnt_r <= age_cnt_r + 1'b1;
            if (age_cnt_r == (SW+1)'(WINDOW_SECONDS - 1)) begin
              clr_all_r <= 1'b0;
              age_cnt_r <= '0;
              if (op_r == act_pkg::OP_QUERY) state_r <= S_OUT;
              else begin
                elapsed_r <= '0;
                last_r[ent_r] <= now_r;
                state_r <= S_UPRD;
              end
            end
          end else begin
            treq_r[ent_r] <= (treq_r[ent_r] > TW'(req_rd)) ? treq_r[ent_r] - TW'(req_rd) : '0;
            tacc_r[ent_r] <= (tacc_r[ent_r] > TW'(acc_rd)) ? tacc_r[ent_r] - TW'(acc_rd) : '0;
            state_r <= S_ARD;
          end
        end
        S_UPRD: begin
          last_r[ent_r] <= now_r;
          state_r <= S_UPWAIT;
        end
        S_UPWAIT: state_r <= S_UPWR;
        S_UPWR: begin
          if (req_rd != BK_MAX && treq_r[ent_r] != TOT_MAX)
            treq_r[ent_r] <= treq_r[ent_r] + 1'b1;
          if (!failed_r && acc_rd != BK_MAX && tacc_r[ent_r] != TOT_MAX)
            tacc_r[ent_r] <= tacc_r[ent_r] + 1'b1;
          state_r <= S_OUT;
        end
        // query: both products are registered together, then compared
        S_QMUL: begin
          limit_r <= (TW+KW)'(tacc_r[ent_r]) * (TW+KW)'(kmul_r);
          lhs_r   <= (TW+17)'(rnd_r) * ((TW+17)'(treq_r[ent_r]) + (TW+17)'(1));
          state_r <= S_QCMP;
        end
        S_QCMP: begin
          res_rej_r <= ((TW+KW)'(treq_r[ent_r]) > limit_r) &&
                       (lhs_r < (TW+17)'({TW'((TW+KW)'(treq_r[ent_r]) - limit_r), 16'd0}));
          state_r <= S_OUT;
        end
        // load the output register once it is free
        S_OUT: if (!rsp_valid_r) begin
          rsp_valid_r <= 1'b1;
          rsp_rej_r   <= res_rej_r;
          rsp_found_r <= res_found_r;
          rsp_full_r  <= res_full_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (rsp_valid_r && out_ch.ready) rsp_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = rsp_valid_r;
  assign out_ch.reject      = rsp_rej_r;
  assign out_ch.entry_found = rsp_found_r;
  assign out_ch.table_full  = rsp_full_r;

  `ACT_ASSERT_IMP(a_rsp_flags, clk, rst_n, out_ch.valid, !(out_ch.reject && out_ch.table_full))
  `ACT_ASSERT_NXT(a_take_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ACT_ASSERT_IMP(a_full_nfound, clk, rst_n, out_ch.valid && out_ch.table_full, !out_ch.entry_found)
endmodule
